@@ sv/b64me_pkg.sv @@
// b64me_pkg: beat types, group record and character constants for the base64 mime encoder
// no dependencies; used by every module of the block
package b64me_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } out_beat_t;

  // one group of up to three bytes, ready to be turned into characters
  typedef struct packed {
    logic        crlf;       // line break goes out before the group
    logic        final_grp;  // group closes the message
    logic [1:0]  nbytes;     // 1 to 3 bytes present
    logic [23:0] word;       // bytes packed big-endian, zero filled
  } grp_t;

  localparam int unsigned GrpQDepth = 4;
  localparam int unsigned GrpQPtrW  = 2;
  localparam int unsigned GrpQCntW  = 3;

  localparam logic [6:0] CHAR_CR  = 7'd13;
  localparam logic [6:0] CHAR_LF  = 7'd10;
  localparam logic [6:0] CHAR_PAD = 7'd61;

  // character steps inside one group
  localparam logic [2:0] STEP_CR   = 3'd0;
  localparam logic [2:0] STEP_LF   = 3'd1;
  localparam logic [2:0] STEP_C0   = 3'd2;
  localparam logic [2:0] STEP_LAST = 3'd5;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26) begin
      c = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'd97 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      c = 7'd48 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      c = 7'd43;
    end else begin
      c = 7'd47;
    end
    return c;
  endfunction

endpackage

@@ sv/base64_mime_encoder.sv @@
// base64_mime_encoder: top level, byte stream in, base64 characters with cr lf breaks out
// a closed group goes into the group queue, then its first character into the output register
// throughput: one byte per cycle in while the 4-entry group queue has room; one character
// per cycle out while pop is held and a group is queued, so a group of 4 or 6 characters sets the rate
// reset: synchronous active-low rst_n empties the queue and output and starts a fresh line
// depends on b64me_pkg, b64me_front, b64me_fifo, b64me_back
module base64_mime_encoder #(
  parameter int unsigned LINE_CHARS = 76
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // byte side
  input  logic                 push,
  output logic                 full,
  input  b64me_pkg::in_beat_t  in_data,
  // character side
  output logic                 empty,
  input  logic                 pop,
  output b64me_pkg::out_beat_t out_data
);

  logic            in_accept;
  logic            grp_push;
  b64me_pkg::grp_t grp_w;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  b64me_pkg::grp_t head;
  logic            out_valid;
  logic            out_take;

  // full reflects only the group queue; bytes that fill a group need no slot
  // but are held off too, which keeps the front free of extra buffering
  assign full      = q_full;
  assign in_accept = push && !q_full;

  // front: packs bytes, places line breaks, pushes one record per group
  b64me_front #(
    .LINE_CHARS(LINE_CHARS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .in_beat (in_data),
    .grp_push(grp_push),
    .grp     (grp_w)
  );

  // group queue decouples byte intake from character output
  b64me_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (grp_push),
    .wr_grp (grp_w),
    .rd_en  (q_pop),
    .q_full (q_full),
    .q_valid(q_valid),
    .rd_grp (head)
  );

  // back: one character per cycle, while pop is held and a group is queued, into an output
  // register that takes a new beat in the same cycle the current one is popped
  assign out_take = pop && out_valid;

  b64me_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .head     (head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_beat (out_data),
    .out_take (out_take)
  );

  assign empty = !out_valid;

endmodule

@@ sv/b64me_front.sv @@
// b64me_front: collects bytes into groups and decides where line breaks fall
// depends on b64me_pkg
module b64me_front #(
  parameter int unsigned LINE_CHARS = 76
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  b64me_pkg::in_beat_t in_beat,
  output logic               grp_push,
  output b64me_pkg::grp_t    grp
);

  localparam logic [7:0] LineLen = 8'(LINE_CHARS);

  logic [15:0] held_r, held_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic        close_grp;
  logic        brk;

  assign close_grp = (fill_r == 2'd2) || in_beat.final_byte;
  assign grp_push  = accept && close_grp;
  assign brk       = (pos_r != 7'd0) && (({1'b0, pos_r} + 8'd4) > LineLen);

  always_comb begin
    grp.crlf      = brk;
    grp.final_grp = in_beat.final_byte;
    grp.nbytes    = fill_r + 2'd1;
    case (fill_r)
      2'd2:    grp.word = {held_r, in_beat.data_byte};
      2'd1:    grp.word = {held_r[7:0], in_beat.data_byte, 8'h00};
      default: grp.word = {in_beat.data_byte, 16'h0000};
    endcase
  end

  always_comb begin
    held_nxt = held_r;
    fill_nxt = fill_r;
    pos_nxt  = pos_r;
    if (accept) begin
      if (close_grp) begin
        held_nxt = 16'h0000;
        fill_nxt = 2'd0;
        if (in_beat.final_byte) begin
          pos_nxt = 7'd0;
        end else if (brk) begin
          pos_nxt = 7'd4;
        end else begin
          pos_nxt = pos_r + 7'd4;
        end
      end else begin
        held_nxt = {held_r[7:0], in_beat.data_byte};
        fill_nxt = fill_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 16'h0000;
      fill_r <= 2'd0;
      pos_r  <= 7'd0;
    end else begin
      held_r <= held_nxt;
      fill_r <= fill_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

@@ sv/b64me_fifo.sv @@
// b64me_fifo: short queue of groups between front and back
// depends on b64me_pkg
module b64me_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  b64me_pkg::grp_t wr_grp,
  input  logic            rd_en,
  output logic            q_full,
  output logic            q_valid,
  output b64me_pkg::grp_t rd_grp
);

  b64me_pkg::grp_t mem_r [b64me_pkg::GrpQDepth];
  logic [b64me_pkg::GrpQPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [b64me_pkg::GrpQCntW-1:0] cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == b64me_pkg::GrpQCntW'(b64me_pkg::GrpQDepth));
  assign q_valid = (cnt_r != '0);
  assign rd_grp  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ sv/b64me_back.sv @@
// b64me_back: walks the head group into the output register, one character per
// cycle while that register is free or popped; depends on b64me_pkg
module b64me_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  b64me_pkg::grp_t     head,
  output logic                q_pop,
  output logic                out_valid,
  output b64me_pkg::out_beat_t out_beat,
  input  logic                out_take
);

  logic [2:0] step_r, step_nxt;
  logic [2:0] eff;
  logic [2:0] idx3;
  logic [1:0] idx;
  logic [5:0] sext;
  logic       load;
  logic       valid_r, valid_nxt;
  b64me_pkg::out_beat_t beat_r, beat_nxt;

  // groups without a line break skip the cr and lf steps
  assign eff  = (step_r == b64me_pkg::STEP_CR && !head.crlf) ? b64me_pkg::STEP_C0 : step_r;
  assign idx3 = eff - b64me_pkg::STEP_C0;
  assign idx  = idx3[1:0];
  assign load = q_valid && (!valid_r || out_take);
  assign q_pop = load && (eff == b64me_pkg::STEP_LAST);

  always_comb begin
    case (idx)
      2'd0:    sext = head.word[23:18];
      2'd1:    sext = head.word[17:12];
      2'd2:    sext = head.word[11:6];
      default: sext = head.word[5:0];
    endcase
  end

  always_comb begin
    beat_nxt.last_char = 1'b0;
    case (eff)
      b64me_pkg::STEP_CR: beat_nxt.out_char = b64me_pkg::CHAR_CR;
      b64me_pkg::STEP_LF: beat_nxt.out_char = b64me_pkg::CHAR_LF;
      default: begin
        beat_nxt.out_char  = (idx > head.nbytes) ? b64me_pkg::CHAR_PAD
                                                 : b64me_pkg::b64_char(sext);
        beat_nxt.last_char = head.final_grp && (idx == 2'd3);
      end
    endcase
  end

  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    if (load) begin
      step_nxt  = (eff == b64me_pkg::STEP_LAST) ? b64me_pkg::STEP_CR : eff + 3'd1;
      valid_nxt = 1'b1;
    end else if (out_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= b64me_pkg::STEP_CR;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

@@ sv/b64me_checker.sv @@
// b64me_checker: port-level assertions for the base64 mime encoder, bound to the top level
// depends on b64me_pkg and base64_mime_encoder
module b64me_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 empty,
  input logic                 pop,
  input b64me_pkg::out_beat_t out_data
);

  // a waiting beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("output beat changed while waiting");

  // reset leaves nothing to read
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("output not empty after reset");

  // a taken cr is followed at once by lf
  a_cr_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && out_data.out_char == b64me_pkg::CHAR_CR)
      |=> (!empty && out_data.out_char == b64me_pkg::CHAR_LF))
    else $error("cr not followed by lf");

  // the message never ends on a line break
  a_last_not_brk: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.last_char)
      |-> (out_data.out_char != b64me_pkg::CHAR_CR && out_data.out_char != b64me_pkg::CHAR_LF))
    else $error("last character is cr or lf");

endmodule

bind base64_mime_encoder b64me_checker u_b64me_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .empty   (empty),
  .pop     (pop),
  .out_data(out_data)
);

@@ tb/sv/base64_mime_encoder_tb.sv @@
// base64_mime_encoder_tb: self-checking bench for the base64 mime encoder, byte beats in,
// character beats out, each checked against an in-bench encoder with line-break tracking
// depends on b64me_pkg and base64_mime_encoder
`timescale 1ns / 1ps

module base64_mime_encoder_tb;

  localparam int unsigned LINE_CHARS = 76;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;
  // standard alphabet, first character in the top byte
  localparam logic [511:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  b64me_pkg::in_beat_t in_data = '0;
  logic full;
  logic empty;
  b64me_pkg::out_beat_t out_data;

  base64_mime_encoder #(
    .LINE_CHARS(LINE_CHARS)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // byte beats waiting to be driven, and characters the encoder owes us
  b64me_pkg::in_beat_t  pending_bytes[$];
  b64me_pkg::out_beat_t expected_chars[$];

  // in-bench encoder state: held bytes of the open group, how many, and line fill
  logic [15:0] grp_held = '0;
  int          grp_fill = 0;
  int          line_pos = 0;

  // run control and bookkeeping
  logic idle_on = 1'b1;
  logic byte_taken = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   err_cnt = 0;
  int   cycle_cnt = 0;
  int   bytes_sent = 0;
  int   msgs_sent = 0;
  int   chars_seen = 0;
  int   breaks_seen = 0;

  // work out the characters one accepted byte beat causes
  task automatic encode_byte(input b64me_pkg::in_beat_t beat);
    logic [23:0] word;
    logic [7:0]  glyph;
    logic [5:0]  six;
    int          nbytes;
    b64me_pkg::out_beat_t ob;
    if (grp_fill == 2 || beat.final_byte) begin
      nbytes = grp_fill + 1;
      case (grp_fill)
        2: word = {grp_held, beat.data_byte};
        1: word = {grp_held[7:0], beat.data_byte, 8'h00};
        default: word = {beat.data_byte, 16'h0000};
      endcase
      // a group never straddles a line: break first if it would not fit
      if (line_pos > 0 && line_pos + 4 > LINE_CHARS) begin
        ob.out_char = b64me_pkg::CHAR_CR;
        ob.last_char = 1'b0;
        expected_chars.push_back(ob);
        ob.out_char = b64me_pkg::CHAR_LF;
        expected_chars.push_back(ob);
        line_pos = 0;
      end
      for (int i = 0; i < 4; i++) begin
        six = word[23 - 6 * i -: 6];
        glyph = B64_ALPHABET[511 - 8 * six -: 8];
        // positions past the bytes present become padding
        ob.out_char = (i > nbytes) ? b64me_pkg::CHAR_PAD : glyph[6:0];
        ob.last_char = (beat.final_byte && i == 3);
        expected_chars.push_back(ob);
      end
      line_pos = (line_pos + 4) & 127;
      grp_held = '0;
      grp_fill = 0;
      // end of message: the next byte starts on a fresh line
      if (beat.final_byte) begin
        line_pos = 0;
      end
    end else begin
      grp_held = {grp_held[7:0], beat.data_byte};
      grp_fill = grp_fill + 1;
    end
  endtask

  task automatic add_byte(input logic [7:0] b, input logic fin);
    b64me_pkg::in_beat_t beat;
    beat.data_byte = b;
    beat.final_byte = fin;
    pending_bytes.push_back(beat);
  endtask

  // a whole message of random content, final flag on its last byte
  task automatic add_message(input int len);
    for (int i = 0; i < len; i++) begin
      add_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // byte side driver: new values at the falling edge, a beat held until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (push && !byte_taken) begin
      // keep offering the same beat while the block is full
    end else if (in_gap > 0) begin
      in_gap = in_gap - 1;
      push <= 1'b0;
    end else if (pending_bytes.size() == 0) begin
      push <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      // start an idle burst that begins with this cycle
      in_gap = $urandom_range(1, 18) - 1;
      push <= 1'b0;
    end else begin
      push <= 1'b1;
      in_data <= pending_bytes[0];
    end
    byte_taken = 1'b0;
  end

  // character side: pop withheld in random bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap = out_gap - 1;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(1, 18) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // accepted beats on both sides, sampled at the rising edge
  always @(posedge clk) begin
    b64me_pkg::out_beat_t want;
    if (rst_n && push && !full) begin
      encode_byte(in_data);
      void'(pending_bytes.pop_front());
      byte_taken = 1'b1;
      bytes_sent = bytes_sent + 1;
      if (in_data.final_byte) begin
        msgs_sent = msgs_sent + 1;
      end
    end
    if (rst_n && pop && !empty) begin
      chars_seen = chars_seen + 1;
      if (out_data.out_char == b64me_pkg::CHAR_CR) begin
        breaks_seen = breaks_seen + 1;
      end
      if (expected_chars.size() == 0) begin
        $error("unexpected character beat: out_char %0d last_char %0d",
               out_data.out_char, out_data.last_char);
        err_cnt = err_cnt + 1;
      end else begin
        want = expected_chars.pop_front();
        if (out_data.out_char !== want.out_char) begin
          $error("out_char: expected %0d, got %0d", want.out_char, out_data.out_char);
          err_cnt = err_cnt + 1;
        end
        if (out_data.last_char !== want.last_char) begin
          $error("last_char: expected %0d, got %0d", want.last_char, out_data.last_char);
          err_cnt = err_cnt + 1;
        end
      end
    end
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still owed",
               cycle_cnt, expected_chars.size());
      $display("base64_mime_encoder_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int rand_bytes;
    int len;
    // reset held from the start, released at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: one-byte messages at both extremes, two padding chars
    add_byte(8'h00, 1'b1);
    add_byte(8'hff, 1'b1);
    // two-byte message, one padding char
    add_byte(8'hff, 1'b0);
    add_byte(8'h00, 1'b1);
    // full groups: all zeros, all '+', all '/'
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    add_byte(8'hfb, 1'b0);
    add_byte(8'hef, 1'b0);
    add_byte(8'hbe, 1'b1);
    add_byte(8'hff, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(8'hff, 1'b1);
    // group then a one-byte tail, group then a two-byte tail
    add_byte(8'h4d, 1'b0);
    add_byte(8'h61, 1'b0);
    add_byte(8'h6e, 1'b0);
    add_byte(8'h41, 1'b1);
    add_byte(8'h01, 1'b0);
    add_byte(8'h02, 1'b0);
    add_byte(8'h04, 1'b0);
    add_byte(8'h08, 1'b0);
    add_byte(8'h10, 1'b1);

    // random: a message that fills one line and just spills over,
    // then short messages of random length
    add_message($urandom_range(LINE_CHARS / 4 * 3 + 1, LINE_CHARS / 4 * 3 + 6));
    rand_bytes = 0;
    while (rand_bytes < 12) begin
      len = $urandom_range(1, 8);
      add_message(len);
      rand_bytes = rand_bytes + len;
    end
    while (pending_bytes.size() != 0 || expected_chars.size() != 0) @(posedge clk);

    // last stretch at full rate on both sides
    idle_on = 1'b0;
    in_gap = 0;
    out_gap = 0;
    add_message($urandom_range(1, 5));
    add_message($urandom_range(3, 8));
    add_message($urandom_range(1, 5));
    while (pending_bytes.size() != 0 || expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_chars.size() != 0) begin
      $error("%0d expected characters never arrived", expected_chars.size());
      err_cnt = err_cnt + 1;
    end
    $display("encoded %0d messages from %0d bytes into %0d characters, %0d line breaks",
             msgs_sent, bytes_sent, chars_seen, breaks_seen);
    if (err_cnt == 0) begin
      $display("base64_mime_encoder_tb OK");
    end else begin
      $display("base64_mime_encoder_tb NOT OK");
    end
    $finish;
  end

endmodule
